/* rtl/cia_pkg.sv */
// ----------------------------------------------------------------------------
// cia_pkg
// Shared types and register codes for the two-timer interrupt register block.
// ----------------------------------------------------------------------------
package cia_pkg;

  typedef enum logic [1:0] {
    MODE_READ  = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_TICK  = 2'd2
  } mode_t;

  localparam logic [3:0] REG_TA_LO = 4'h4;
  localparam logic [3:0] REG_TA_HI = 4'h5;
  localparam logic [3:0] REG_TB_LO = 4'h6;
  localparam logic [3:0] REG_TB_HI = 4'h7;
  localparam logic [3:0] REG_ICR   = 4'hD;
  localparam logic [3:0] REG_CRA   = 4'hE;
  localparam logic [3:0] REG_CRB   = 4'hF;

  localparam int IntW = 5;

  localparam int CtrlRunBit     = 0;
  localparam int CtrlOneshotBit = 3;
  localparam int CtrlLoadBit    = 4;
  localparam int IcrSetBit      = 7;

  localparam int IntTaBit = 0;
  localparam int IntTbBit = 1;

  typedef struct packed {
    logic       tick;
    logic       wr_lo;
    logic       wr_hi;
    logic       wr_ctrl;
    logic [7:0] data;
  } tmr_cmd_t;

endpackage

/* rtl/cia_timer_interrupt_block_unit.sv */
// ----------------------------------------------------------------------------
// cia_timer_interrupt_block_unit
// Register block with two down timers, interrupt mask/status and plain bytes.
// ----------------------------------------------------------------------------
//  channel | ports                                          | direction
//  --------+------------------------------------------------+----------
//  in      | in_valid in_ready in_mode in_reg_addr           | to block
//          | in_write_data                                  |
//  out     | out_valid out_ready out_read_data out_irq       | from block
//
//  Every word is applied in the cycle it is accepted; its result word sits in
//  the output register from the next cycle. One word per cycle if not stalled.
//  A new word is taken whenever the output register is empty or being drained.
//  Synchronous active-low reset clears all but output data/irq; timers stopped.
// ----------------------------------------------------------------------------
module cia_timer_interrupt_block_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_mode,
  input  logic [3:0] in_reg_addr,
  input  logic [7:0] in_write_data,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_read_data,
  output logic       out_irq
);
  import cia_pkg::*;

  logic            accept;
  mode_t           mode;
  logic            do_rd, do_wr, do_tick;

  logic [7:0]      plain_r [16];
  logic [IntW-1:0] mask_r, mask_nxt;
  logic [IntW-1:0] stat_r, stat_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [7:0]      out_data_r;
  logic            out_irq_r;
  logic [7:0]      rd_data;

  tmr_cmd_t        cmd_a, cmd_b;
  logic [15:0]     count_a, count_b;
  logic [7:0]      ctrl_a, ctrl_b;
  logic            unf_a, unf_b;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign mode     = mode_t'(in_mode);

  always_comb begin
    do_rd   = 1'b0;
    do_wr   = 1'b0;
    do_tick = 1'b0;
    case (mode)
      MODE_READ:  do_rd   = accept;
      MODE_WRITE: do_wr   = accept;
      MODE_TICK:  do_tick = accept;
      default: ;
    endcase
  end

  always_comb begin
    cmd_a.tick    = do_tick;
    cmd_a.wr_lo   = do_wr && (in_reg_addr == REG_TA_LO);
    cmd_a.wr_hi   = do_wr && (in_reg_addr == REG_TA_HI);
    cmd_a.wr_ctrl = do_wr && (in_reg_addr == REG_CRA);
    cmd_a.data    = in_write_data;
    cmd_b.tick    = do_tick;
    cmd_b.wr_lo   = do_wr && (in_reg_addr == REG_TB_LO);
    cmd_b.wr_hi   = do_wr && (in_reg_addr == REG_TB_HI);
    cmd_b.wr_ctrl = do_wr && (in_reg_addr == REG_CRB);
    cmd_b.data    = in_write_data;
  end

  cia_tmr u_tmr_a (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd_a),
    .count     (count_a),
    .ctrl      (ctrl_a),
    .underflow (unf_a)
  );

  cia_tmr u_tmr_b (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd_b),
    .count     (count_b),
    .ctrl      (ctrl_b),
    .underflow (unf_b)
  );

  always_comb begin
    case (in_reg_addr)
      REG_TA_LO: rd_data = count_a[7:0];
      REG_TA_HI: rd_data = count_a[15:8];
      REG_TB_LO: rd_data = count_b[7:0];
      REG_TB_HI: rd_data = count_b[15:8];
      REG_ICR:   rd_data = {{(8 - IntW){1'b0}}, stat_r};
      REG_CRA:   rd_data = ctrl_a;
      REG_CRB:   rd_data = ctrl_b;
      default:   rd_data = plain_r[in_reg_addr];
    endcase
  end

  always_comb begin
    mask_nxt = mask_r;
    stat_nxt = stat_r;
    if (do_wr && (in_reg_addr == REG_ICR)) begin
      if (in_write_data[IcrSetBit]) begin
        mask_nxt = mask_r | in_write_data[IntW-1:0];
      end else begin
        mask_nxt = mask_r & ~in_write_data[IntW-1:0];
      end
    end
    if (do_rd && (in_reg_addr == REG_ICR)) begin
      stat_nxt = '0;
    end
    if (unf_a) begin
      stat_nxt[IntTaBit] = 1'b1;
    end
    if (unf_b) begin
      stat_nxt[IntTbBit] = 1'b1;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r      <= '0;
      stat_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 16; i++) begin
        plain_r[i] <= '0;
      end
    end else begin
      mask_r      <= mask_nxt;
      stat_r      <= stat_nxt;
      out_valid_r <= out_valid_nxt;
      if (do_wr) begin
        plain_r[in_reg_addr] <= in_write_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= do_rd ? rd_data : 8'h00;
      out_irq_r  <= |(mask_nxt & stat_nxt);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = out_data_r;
  assign out_irq       = out_irq_r;

endmodule

/* rtl/cia_tmr.sv */
// ----------------------------------------------------------------------------
// cia_tmr
// One 16-bit down timer with reload latch, control byte and underflow flag.
// ----------------------------------------------------------------------------
module cia_tmr (
  input  logic              clk,
  input  logic              rst_n,
  input  cia_pkg::tmr_cmd_t cmd,
  output logic [15:0]       count,
  output logic [7:0]        ctrl,
  output logic              underflow
);
  import cia_pkg::*;

  logic [15:0] count_r, count_nxt;
  logic [15:0] latch_r, latch_nxt;
  logic [7:0]  ctrl_r, ctrl_nxt;

  assign underflow = cmd.tick && ctrl_r[CtrlRunBit] && (count_r == 16'h0000);

  always_comb begin
    count_nxt = count_r;
    latch_nxt = latch_r;
    ctrl_nxt  = ctrl_r;
    if (cmd.wr_lo) begin
      latch_nxt[7:0] = cmd.data;
    end
    if (cmd.wr_hi) begin
      latch_nxt[15:8] = cmd.data;
    end
    if (cmd.wr_ctrl) begin
      if (cmd.data[CtrlLoadBit]) begin
        count_nxt = latch_r;
      end
      ctrl_nxt              = cmd.data;
      ctrl_nxt[CtrlLoadBit] = 1'b0;
    end
    if (cmd.tick && ctrl_r[CtrlRunBit]) begin
      if (count_r == 16'h0000) begin
        if (ctrl_r[CtrlOneshotBit]) begin
          count_nxt            = 16'hFFFF;
          ctrl_nxt[CtrlRunBit] = 1'b0;
        end else begin
          count_nxt = latch_r;
        end
      end else begin
        count_nxt = count_r - 16'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      latch_r <= '0;
      ctrl_r  <= '0;
    end else begin
      count_r <= count_nxt;
      latch_r <= latch_nxt;
      ctrl_r  <= ctrl_nxt;
    end
  end

  assign count = count_r;
  assign ctrl  = ctrl_r;

endmodule

/* dv/cia_timer_interrupt_block_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cia_timer_interrupt_block_unit_tb
// Self-checking bench for the two-timer interrupt register block.
// Register reads, writes and timer ticks are sent over the input channel. A
// behavioral copy of the timers, latches, control bytes, interrupt mask and
// status predicts the read byte and irq of every word. Each returned word is
// checked against the oldest prediction, under random gaps and stalls on
// both channels.
// ----------------------------------------------------------------------------
module cia_timer_interrupt_block_unit_tb;
  import cia_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int HoldCycles     = 64;
  localparam int WatchdogLimit  = 2000;
  localparam int ReportLimit    = 10;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq;
  } cia_result_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] in_mode = 2'd0;
  logic [3:0] in_reg_addr = 4'd0;
  logic [7:0] in_write_data = 8'd0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_read_data;
  logic       out_irq;

  cia_timer_interrupt_block_unit dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_mode      (in_mode),
    .in_reg_addr  (in_reg_addr),
    .in_write_data(in_write_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_read_data(out_read_data),
    .out_irq      (out_irq)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Predicted block state
  logic [7:0]    plain_bytes [16];
  logic [15:0]   cnt_a, cnt_b, lat_a, lat_b;
  logic [7:0]    ctl_a, ctl_b;
  logic [IntW-1:0] irq_mask, irq_status;

  cia_result_t pending_results[$];
  int          mismatches = 0;
  int          words_checked = 0;
  int          idle_cycles = 0;
  bit          steady = 1'b0;
  bit          hold_req = 1'b0;

  function automatic void step_timer(input logic [15:0] cnt_i, input logic [15:0] lat,
                                     input logic [7:0] ctl_i, output logic [15:0] cnt_o,
                                     output logic [7:0] ctl_o, output logic underflow);
    cnt_o = cnt_i;
    ctl_o = ctl_i;
    underflow = 1'b0;
    if (ctl_i[CtrlRunBit]) begin
      if (cnt_i == 16'd0) begin
        underflow = 1'b1;
        if (ctl_i[CtrlOneshotBit]) begin
          cnt_o = 16'hFFFF;
          ctl_o[CtrlRunBit] = 1'b0;
        end else begin
          cnt_o = lat;
        end
      end else begin
        cnt_o = cnt_i - 16'd1;
      end
    end
  endfunction

  function automatic void apply_word(input logic [1:0] mode_v, input logic [3:0] addr,
                                     input logic [7:0] data);
    cia_result_t res;
    logic        uf;
    res.read_data = 8'd0;
    case (mode_v)
      MODE_READ: begin
        case (addr)
          REG_TA_LO: res.read_data = cnt_a[7:0];
          REG_TA_HI: res.read_data = cnt_a[15:8];
          REG_TB_LO: res.read_data = cnt_b[7:0];
          REG_TB_HI: res.read_data = cnt_b[15:8];
          REG_ICR: begin
            res.read_data = 8'(irq_status);
            irq_status = '0;
          end
          REG_CRA: res.read_data = ctl_a;
          REG_CRB: res.read_data = ctl_b;
          default: res.read_data = plain_bytes[addr];
        endcase
      end
      MODE_WRITE: begin
        case (addr)
          REG_TA_LO: lat_a[7:0] = data;
          REG_TA_HI: lat_a[15:8] = data;
          REG_TB_LO: lat_b[7:0] = data;
          REG_TB_HI: lat_b[15:8] = data;
          REG_ICR: begin
            if (data[IcrSetBit]) irq_mask = irq_mask | data[IntW-1:0];
            else irq_mask = irq_mask & ~data[IntW-1:0];
          end
          REG_CRA: begin
            if (data[CtrlLoadBit]) cnt_a = lat_a;
            ctl_a = data;
            ctl_a[CtrlLoadBit] = 1'b0;
          end
          REG_CRB: begin
            if (data[CtrlLoadBit]) cnt_b = lat_b;
            ctl_b = data;
            ctl_b[CtrlLoadBit] = 1'b0;
          end
          default: plain_bytes[addr] = data;
        endcase
      end
      MODE_TICK: begin
        step_timer(cnt_a, lat_a, ctl_a, cnt_a, ctl_a, uf);
        if (uf) irq_status[IntTaBit] = 1'b1;
        step_timer(cnt_b, lat_b, ctl_b, cnt_b, ctl_b, uf);
        if (uf) irq_status[IntTbBit] = 1'b1;
      end
      default: ;
    endcase
    res.irq = |(irq_mask & irq_status);
    pending_results.push_back(res);
  endfunction

  task automatic clear_model();
    foreach (plain_bytes[i]) plain_bytes[i] = 8'd0;
    cnt_a = '0;
    cnt_b = '0;
    lat_a = '0;
    lat_b = '0;
    ctl_a = '0;
    ctl_b = '0;
    irq_mask = '0;
    irq_status = '0;
  endtask

  task automatic send_word(input logic [1:0] mode_v, input logic [3:0] addr,
                           input logic [7:0] data);
    if (!steady) begin
      while ($urandom_range(99) < 19) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid      <= 1'b1;
    in_mode       <= mode_v;
    in_reg_addr   <= addr;
    in_write_data <= data;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    apply_word(mode_v, addr, data);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [3:0] pick_timer_reg();
    case ($urandom_range(6))
      0: return REG_TA_LO;
      1: return REG_TA_HI;
      2: return REG_TB_LO;
      3: return REG_TB_HI;
      4: return REG_ICR;
      5: return REG_CRA;
      default: return REG_CRB;
    endcase
  endfunction

  task automatic send_random_word();
    int         pick;
    logic [1:0] mode_v;
    logic [3:0] addr;
    logic [7:0] data;
    pick   = $urandom_range(99);
    addr   = 4'($urandom_range(15));
    data   = 8'($urandom_range(255));
    mode_v = MODE_READ;
    if (pick < 35) begin
      mode_v = MODE_TICK;
    end else if (pick < 70) begin
      mode_v = MODE_WRITE;
      if ($urandom_range(3) != 0) addr = pick_timer_reg();
      case (addr)
        REG_TA_LO, REG_TB_LO: if ($urandom_range(9) < 7) data = 8'($urandom_range(7));
        REG_TA_HI, REG_TB_HI: if ($urandom_range(9) < 7) data = 8'd0;
        REG_CRA, REG_CRB:     if ($urandom_range(9) < 6) data[CtrlRunBit] = 1'b1;
        default: ;
      endcase
    end else if (pick < 97) begin
      if ($urandom_range(1) != 0) addr = pick_timer_reg();
    end else begin
      mode_v = MODE_UNUSED;
    end
    send_word(mode_v, addr, data);
  endtask

  task automatic test_directed();
    send_word(MODE_UNUSED, 4'hF, 8'hFF);
    send_word(MODE_READ, REG_ICR, 8'h00);
    send_word(MODE_WRITE, REG_TA_LO, 8'h02);
    send_word(MODE_WRITE, REG_TA_HI, 8'h00);
    send_word(MODE_WRITE, REG_TB_LO, 8'h01);
    send_word(MODE_WRITE, REG_TB_HI, 8'h00);
    send_word(MODE_WRITE, REG_ICR, 8'h9F);
    // A continuous with load, B one-shot with load
    send_word(MODE_WRITE, REG_CRA, 8'h11);
    send_word(MODE_WRITE, REG_CRB, 8'h19);
    repeat (4) send_word(MODE_TICK, 4'h0, 8'h00);
    send_word(MODE_READ, REG_ICR, 8'h00);
    send_word(MODE_READ, REG_TB_LO, 8'h00);
    send_word(MODE_READ, REG_TB_HI, 8'h00);
    send_word(MODE_READ, REG_CRB, 8'h00);
    send_word(MODE_WRITE, REG_ICR, 8'h03);
    send_word(MODE_WRITE, 4'h0, 8'hFF);
    send_word(MODE_READ, 4'h0, 8'h00);
    send_word(MODE_WRITE, REG_CRA, 8'h00);
    send_word(MODE_READ, REG_TA_LO, 8'h00);
    send_word(MODE_WRITE, REG_TA_LO, 8'hFF);
    send_word(MODE_WRITE, REG_TA_HI, 8'hFF);
    send_word(MODE_WRITE, REG_CRA, 8'h10);
    send_word(MODE_READ, REG_TA_HI, 8'h00);
    send_word(MODE_READ, REG_CRA, 8'h00);
  endtask

  task automatic test_random(input int count);
    repeat (count) send_random_word();
  endtask

  task automatic test_backpressure();
    hold_req = 1'b1;
    repeat (24) send_random_word();
  endtask

  task automatic test_sender_pause();
    repeat (30) send_random_word();
    wait_drain();
    repeat (30) send_random_word();
  endtask

  task automatic test_back_to_back();
    steady = 1'b1;
    repeat (200) send_random_word();
    steady = 1'b0;
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end else begin
        out_ready <= steady || ($urandom_range(99) >= 19);
      end
    end
  end

  always @(posedge clk) begin
    cia_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportLimit)
          $display("unexpected word: read_data %h irq %b", out_read_data, out_irq);
      end else begin
        want = pending_results.pop_front();
        if (want.read_data !== out_read_data || want.irq !== out_irq) begin
          mismatches++;
          if (mismatches <= ReportLimit)
            $display("word %0d: read_data exp %h got %h, irq exp %b got %b", words_checked,
                     want.read_data, out_read_data, want.irq, out_irq);
        end
      end
      words_checked++;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    clear_model();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(500);
    test_backpressure();
    test_sender_pause();
    test_back_to_back();
    test_random(600);
    wait_drain();
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
